>>> rtl/core/qoe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qoe_pkg: shared types and constants for the orientation error block
// Beat layouts of the input and result channels, configuration register
// indexes and reset values, step counts, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qoe_pkg;

    // Quaternion fields are signed Q1.15; error components are signed Q3.13.
    localparam int QW = 16;

    typedef struct packed {
        logic signed [QW-1:0] want_w;
        logic signed [QW-1:0] want_x;
        logic signed [QW-1:0] want_y;
        logic signed [QW-1:0] want_z;
        logic signed [QW-1:0] now_w;
        logic signed [QW-1:0] now_x;
        logic signed [QW-1:0] now_y;
        logic signed [QW-1:0] now_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [QW-1:0] err_x;
        logic signed [QW-1:0] err_y;
        logic signed [QW-1:0] err_z;
        logic                 used_small_angle;
        logic                 degenerate;
    } t_out_beat;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 1'd1;

    // Reset: logarithmic error, limit of about 0.001 in Q0.16
    localparam logic        ERROR_KIND_RST = 1'b1;
    localparam logic [15:0] NEAR_LIMIT_RST = 16'd66;

    // CORDIC depth and the fixed step counts of the root and divide units
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int SQRT_STEPS       = 32;
    localparam int DIV_STEPS        = 32;

    // atan(2^-i) in Q2.30 radians, truncated
    function automatic logic [29:0] atan_q30(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314856;
            1:       v = 30'd497837829;
            2:       v = 30'd263043836;
            3:       v = 30'd133525158;
            4:       v = 30'd67021686;
            5:       v = 30'd33543515;
            6:       v = 30'd16775850;
            7:       v = 30'd8388437;
            8:       v = 30'd4194282;
            9:       v = 30'd2097149;
            10:      v = 30'd1048575;
            11:      v = 30'd524287;
            12:      v = 30'd262143;
            13:      v = 30'd131071;
            14:      v = 30'd65535;
            15:      v = 30'd32767;
            16:      v = 30'd16383;
            17:      v = 30'd8191;
            18:      v = 30'd4095;
            19:      v = 30'd2047;
            20:      v = 30'd1023;
            21:      v = 30'd511;
            22:      v = 30'd255;
            23:      v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/qoe_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qoe_stream_if: valid/ready stream channel
// Carries one beat of type T per handshake; source drives valid and data,
// sink drives ready.
// ----------------------------------------------------------------------------
interface qoe_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/quaternion_orientation_error.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_orientation_error: error vector between two attitude quaternions
// Forms want * conj(now), folds to w >= 0 and returns the normalized vector
// part, twice that near identity, or the log-map theta * v/|v| (CORDIC angle).
//
// Usage:
//   i_in   : sink of t_in_beat, desired and current quaternion (Q1.15).
//   o_out  : source of t_out_beat, err_x/y/z (Q3.13, saturated) and flags.
//   i_cfg_*: write port; index 0 selects the error kind, index 1 sets the
//            near-identity limit on 1 - w^2. Write only while idle.
// Throughput: one beat per cycle unless stalled; exactly one result per beat.
// Pipeline: front stages, the 32-step root extraction, the decision stage, the
//   32-step divider (root and divider each one bit per pipeline stage), the
//   multiply stage and the output register; CORDIC_STEPS does not add stages.
// Stall: all stages advance together. A two-entry output buffer (output
//   register plus skid) takes the last result while the receiver stalls;
//   i_in.ready drops only once the skid entry is full, and no beat is
//   dropped or repeated.
// Reset: synchronous, active low; clears all valid bits and loads the
//   configuration reset values (log error, limit 66).
// ----------------------------------------------------------------------------
module quaternion_orientation_error #(
    parameter int CORDIC_STEPS = qoe_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qoe_stream_if.sink                     i_in,
    qoe_stream_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic [qoe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qoe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qoe_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_SMALL,
        MODE_LOG
    } t_err_mode;

    // Per-item payload that rides along from the fold stage to the decision stage
    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       negc;
        logic             zero;
        logic [30:0]      w;
    } t_item;

    typedef struct packed {
        t_item       it;
        logic        lt;
        logic [63:0] nrem;
        logic [63:0] nres;
        logic [63:0] vrem;
        logic [63:0] vres;
    } t_sq;

    typedef struct packed {
        t_err_mode        mode;
        logic [2:0]       negc;
        logic             zero;
        logic [31:0]      dvs;
        logic [2:0][31:0] rem;
        logic [2:0][31:0] quo;
        logic [34:0]      cx;
        logic [34:0]      cy;
        logic [32:0]      cz;
    } t_dv;

    typedef struct packed {
        t_err_mode        mode;
        logic [2:0]       negc;
        logic             zero;
        logic [2:0][31:0] quo;
        logic [2:0][62:0] prod;
    } t_ml;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_error_kind;
    logic [15:0] r_near_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_kind <= ERROR_KIND_RST;
            r_near_limit <= NEAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ERROR_KIND: r_error_kind <= i_cfg_data[0];
                CFG_NEAR_LIMIT: r_near_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves while the skid entry is free
    // ------------------------------------------------------------------
    logic w_en;
    logic r_ov;
    logic r_sv;

    assign w_en       = !r_sv;
    assign i_in.ready = w_en;

    // ------------------------------------------------------------------
    // Stage 1: sixteen cross products want_i * now_j
    // ------------------------------------------------------------------
    logic signed [15:0] w_a [4];
    logic signed [15:0] w_b [4];
    logic signed [31:0] n_p [4][4];
    logic signed [31:0] r_p [4][4];
    logic               r_v1;

    assign w_a[0] = i_in.data.want_w;
    assign w_a[1] = i_in.data.want_x;
    assign w_a[2] = i_in.data.want_y;
    assign w_a[3] = i_in.data.want_z;
    assign w_b[0] = i_in.data.now_w;
    assign w_b[1] = i_in.data.now_x;
    assign w_b[2] = i_in.data.now_y;
    assign w_b[3] = i_in.data.now_z;

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                n_p[a][b] = 32'(w_a[a] * w_b[b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_p <= n_p;
    end

    // ------------------------------------------------------------------
    // Stage 2: difference quaternion, Q2.30 sums floored to Q2.28
    // ------------------------------------------------------------------
    logic signed [33:0] n_sum [4];
    logic signed [31:0] r_q   [4];
    logic               r_v2;

    always_comb begin
        n_sum[0] = 34'(r_p[0][0]) + 34'(r_p[1][1]) + 34'(r_p[2][2]) + 34'(r_p[3][3]);
        n_sum[1] = -34'(r_p[0][1]) + 34'(r_p[1][0]) - 34'(r_p[2][3]) + 34'(r_p[3][2]);
        n_sum[2] = -34'(r_p[0][2]) + 34'(r_p[2][0]) - 34'(r_p[3][1]) + 34'(r_p[1][3]);
        n_sum[3] = -34'(r_p[0][3]) + 34'(r_p[3][0]) - 34'(r_p[1][2]) + 34'(r_p[2][1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) r_q[k] <= n_sum[k][33:2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: fold to w >= 0, split vector part into sign and magnitude
    // ------------------------------------------------------------------
    logic               n3_flip;
    logic signed [32:0] n3_c [4];
    t_item              n3_it;
    t_item              r3_it;
    logic               r_v3;

    always_comb begin
        n3_flip = r_q[0][31];
        for (int k = 0; k < 4; k++) begin
            n3_c[k] = n3_flip ? -33'(r_q[k]) : 33'(r_q[k]);
        end
        n3_it.zero = (r_q[0] == '0) && (r_q[1] == '0) && (r_q[2] == '0) && (r_q[3] == '0);
        n3_it.w    = n3_c[0][30:0];
        for (int k = 0; k < 3; k++) begin
            n3_it.negc[k] = n3_c[k+1][32];
            n3_it.mag[k]  = n3_c[k+1][32] ? 31'(-n3_c[k+1]) : n3_c[k+1][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r3_it <= n3_it;
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of the four parts
    // ------------------------------------------------------------------
    logic [60:0] n4_sq [3];
    logic [60:0] n4_ww;
    logic [60:0] r4_sq [3];
    logic [60:0] r4_ww;
    t_item       r4_it;
    logic        r_v4;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_sq[k] = 61'(62'(r3_it.mag[k]) * 62'(r3_it.mag[k]));
        end
        n4_ww = 61'(62'(r3_it.w) * 62'(r3_it.w));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sq <= n4_sq;
            r4_ww <= n4_ww;
            r4_it <= r3_it;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: |v|^2 and |q|^2
    // ------------------------------------------------------------------
    logic [61:0] n5_v2;
    logic [61:0] r5_v2;
    logic [62:0] r5_n2;
    t_item       r5_it;
    logic        r_v5;

    assign n5_v2 = 62'(r4_sq[0]) + 62'(r4_sq[1]) + 62'(r4_sq[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_v2 <= n5_v2;
            r5_n2 <= 63'(n5_v2) + 63'(r4_ww);
            r5_it <= r4_it;
        end
    end

    // ------------------------------------------------------------------
    // Stages 6-8: exact near-identity test |v|^2 * 2^16 < limit * |q|^2,
    // limit * |q|^2 built from 16 x 32 and 16 x 31 partial products
    // ------------------------------------------------------------------
    logic [47:0] r6_pl;
    logic [46:0] r6_ph;
    logic [61:0] r6_v2;
    logic [62:0] r6_n2;
    t_item       r6_it;
    logic        r_v6;
    logic [78:0] r7_rhs;
    logic [61:0] r7_v2;
    logic [62:0] r7_n2;
    t_item       r7_it;
    logic        r_v7;
    logic        r8_lt;
    logic [61:0] r8_v2;
    logic [62:0] r8_n2;
    t_item       r8_it;
    logic        r_v8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_pl  <= 48'(r_near_limit) * 48'(r5_n2[31:0]);
            r6_ph  <= 47'(r_near_limit) * 47'(r5_n2[62:32]);
            r6_v2  <= r5_v2;
            r6_n2  <= r5_n2;
            r6_it  <= r5_it;
            r7_rhs <= {r6_ph, 32'd0} + 79'(r6_pl);
            r7_v2  <= r6_v2;
            r7_n2  <= r6_n2;
            r7_it  <= r6_it;
            r8_lt  <= {1'b0, r7_v2, 16'd0} < r7_rhs;
            r8_v2  <= r7_v2;
            r8_n2  <= r7_n2;
            r8_it  <= r7_it;
        end
    end

    // ------------------------------------------------------------------
    // Square roots of |q|^2 and |v|^2: two bits of radicand per stage
    // ------------------------------------------------------------------
    t_sq  r_sq   [SQRT_STEPS];
    logic r_sq_v [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
        t_sq         s_in;
        t_sq         s_nx;
        logic [63:0] s_nsum;
        logic [63:0] s_vsum;

        if (i == 0) begin : g_src0
            always_comb begin
                s_in.it   = r8_it;
                s_in.lt   = r8_lt;
                s_in.nrem = 64'(r8_n2);
                s_in.nres = '0;
                s_in.vrem = 64'(r8_v2);
                s_in.vres = '0;
            end
        end else begin : g_srcn
            assign s_in = r_sq[i-1];
        end

        assign s_nsum = s_in.nres + BIT;
        assign s_vsum = s_in.vres + BIT;

        always_comb begin
            s_nx = s_in;
            if (s_in.nrem >= s_nsum) begin
                s_nx.nrem = s_in.nrem - s_nsum;
                s_nx.nres = (s_in.nres >> 1) + BIT;
            end else begin
                s_nx.nres = s_in.nres >> 1;
            end
            if (s_in.vrem >= s_vsum) begin
                s_nx.vrem = s_in.vrem - s_vsum;
                s_nx.vres = (s_in.vres >> 1) + BIT;
            end else begin
                s_nx.vres = s_in.vres >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) r_sq[i] <= s_nx;
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: pick the error form and the divisor
    //   plain : F = |c| * 2^31 / |q|, out = round(F / 2^18)
    //   small : same divisor,          out = round(F / 2^17)
    //   log   : F = |c| * 2^31 / |v|,  out = (theta * F/2 + 2^46) >> 47
    // ------------------------------------------------------------------
    t_sq         w_sqo;
    logic [31:0] w_nq;
    logic [31:0] w_vm;
    t_dv         n_dc;
    t_dv         r_dc;
    logic        r_dc_v;

    assign w_sqo = r_sq[SQRT_STEPS-1];
    assign w_nq  = w_sqo.nres[31:0];
    assign w_vm  = w_sqo.vres[31:0];

    always_comb begin
        if (r_error_kind == 1'b0) begin
            n_dc.mode = MODE_PLAIN;
        end else if ((w_vm == '0) || w_sqo.lt) begin
            n_dc.mode = MODE_SMALL;
        end else begin
            n_dc.mode = MODE_LOG;
        end
        n_dc.negc = w_sqo.it.negc;
        n_dc.zero = w_sqo.it.zero;
        n_dc.dvs  = (n_dc.mode == MODE_LOG) ? w_vm : w_nq;
        for (int k = 0; k < 3; k++) begin
            n_dc.rem[k] = 32'(w_sqo.it.mag[k]);
            n_dc.quo[k] = '0;
        end
        n_dc.cx = 35'(w_sqo.it.w);
        n_dc.cy = 35'(w_vm);
        n_dc.cz = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_dc <= n_dc;
    end

    // ------------------------------------------------------------------
    // Divider, one quotient bit per stage, with the CORDIC vectoring
    // rotations of angle atan2(|v|, w) in the first CORDIC_STEPS stages
    // ------------------------------------------------------------------
    t_dv  r_dv   [DIV_STEPS];
    logic r_dv_v [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        t_dv s_in;
        t_dv s_nx;

        if (j == 0) begin : g_src0
            assign s_in = r_dc;
        end else begin : g_srcn
            assign s_in = r_dv[j-1];
        end

        always_comb begin
            logic [32:0]        trial;
            logic signed [34:0] sx;
            logic signed [34:0] sy;
            logic signed [34:0] dx;
            logic signed [34:0] dy;
            logic signed [32:0] sz;
            s_nx = s_in;
            for (int k = 0; k < 3; k++) begin
                trial = (j == 0) ? {1'b0, s_in.rem[k]} : {s_in.rem[k], 1'b0};
                if (trial >= {1'b0, s_in.dvs}) begin
                    s_nx.rem[k]        = 32'(trial - {1'b0, s_in.dvs});
                    s_nx.quo[k][31-j]  = 1'b1;
                end else begin
                    s_nx.rem[k]        = trial[31:0];
                end
            end
            sx = $signed(s_in.cx);
            sy = $signed(s_in.cy);
            sz = $signed(s_in.cz);
            dx = sy >>> j;
            dy = sx >>> j;
            if (j < CORDIC_STEPS) begin
                if (sy > 0) begin
                    s_nx.cx = sx + dx;
                    s_nx.cy = sy - dy;
                    s_nx.cz = sz + 33'(atan_q30(j));
                end else begin
                    s_nx.cx = sx - dx;
                    s_nx.cy = sy + dy;
                    s_nx.cz = sz - 33'(atan_q30(j));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) r_dv[j] <= s_nx;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: theta = 2 * max(angle, 0), times u = F / 2
    // ------------------------------------------------------------------
    t_dv         w_dvo;
    logic [31:0] w_theta;
    t_ml         n_ml;
    t_ml         r_ml;
    logic        r_ml_v;

    assign w_dvo   = r_dv[DIV_STEPS-1];
    assign w_theta = w_dvo.cz[32] ? '0 : {w_dvo.cz[30:0], 1'b0};

    always_comb begin
        n_ml.mode = w_dvo.mode;
        n_ml.negc = w_dvo.negc;
        n_ml.zero = w_dvo.zero;
        n_ml.quo  = w_dvo.quo;
        for (int k = 0; k < 3; k++) begin
            n_ml.prod[k] = 63'(w_theta) * 63'(w_dvo.quo[k][31:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_ml <= n_ml;
    end

    // ------------------------------------------------------------------
    // Round, apply sign, saturate to 16 bits
    // ------------------------------------------------------------------
    logic [16:0]          w_mg  [3];
    logic signed [15:0]   w_val [3];
    t_out_beat            w_res;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_ml.mode)
                MODE_PLAIN: w_mg[k] = 17'((17'(r_ml.quo[k][31:17]) + 17'd1) >> 1);
                MODE_SMALL: w_mg[k] = 17'((17'(r_ml.quo[k][31:16]) + 17'd1) >> 1);
                MODE_LOG:   w_mg[k] = 17'((64'(r_ml.prod[k]) + (64'(1) << 46)) >> 47);
                default:    w_mg[k] = '0;
            endcase
            if (r_ml.zero) begin
                w_val[k] = '0;
            end else if (r_ml.negc[k]) begin
                w_val[k] = (w_mg[k] > 17'd32768) ? 16'sh8000 : 16'(-w_mg[k]);
            end else begin
                w_val[k] = (w_mg[k] > 17'd32767) ? 16'sh7fff : w_mg[k][15:0];
            end
        end
        w_res.err_x            = w_val[0];
        w_res.err_y            = w_val[1];
        w_res.err_z            = w_val[2];
        w_res.used_small_angle = (r_ml.mode == MODE_SMALL) && !r_ml.zero;
        w_res.degenerate       = r_ml.zero;
    end

    // ------------------------------------------------------------------
    // Valid bits: advance with the data, clear on reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_dc_v <= 1'b0;
            r_ml_v <= 1'b0;
            for (int i = 0; i < SQRT_STEPS; i++) r_sq_v[i] <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++) r_dv_v[j] <= 1'b0;
        end else if (w_en) begin
            r_v1      <= i_in.valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_v8      <= r_v7;
            r_sq_v[0] <= r_v8;
            for (int i = 1; i < SQRT_STEPS; i++) r_sq_v[i] <= r_sq_v[i-1];
            r_dc_v    <= r_sq_v[SQRT_STEPS-1];
            r_dv_v[0] <= r_dc_v;
            for (int j = 1; j < DIV_STEPS; j++) r_dv_v[j] <= r_dv_v[j-1];
            r_ml_v    <= r_dv_v[DIV_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    t_out_beat r_od;
    t_out_beat r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_en) begin
            if (!r_ov || o_out.ready) begin
                r_ov <= r_ml_v;
            end else begin
                r_sv <= r_ml_v;
            end
        end else if (o_out.ready) begin
            // drain the skid entry into the output register
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_ov || o_out.ready) begin
                r_od <= w_res;
            end else begin
                r_sd <= w_res;
            end
        end else if (o_out.ready) begin
            r_od <= r_sd;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds a beat while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !o_out.ready))
        else $error("skid entry filled without a stalled output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.degenerate) |->
            (!o_out.data.used_small_angle && (o_out.data.err_x == '0)
             && (o_out.data.err_y == '0) && (o_out.data.err_z == '0)))
        else $error("zero difference quaternion gave a nonzero error");

endmodule
`default_nettype wire

>>> test/quaternion_orientation_error_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_orientation_error_test: self-checking bench for the error block
// Drives desired/current quaternion pairs through the stream channels,
// predicts each error vector with a bit-exact fixed-point model and checks
// every result beat in order, under random idling, stalls and several
// register settings.
// ----------------------------------------------------------------------------
module quaternion_orientation_error_test;
    import qoe_pkg::*;

    localparam int LATENCY = 75;
    localparam int STEPS   = CORDIC_STEPS_DEF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qoe_stream_if #(.T(t_in_beat))  in_ch ();
    qoe_stream_if #(.T(t_out_beat)) out_ch ();

    quaternion_orientation_error #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the configuration registers
    logic        log_kind;
    logic [15:0] near_limit;

    t_out_beat errors_due[$];
    int        fail_count;
    logic      calm;       // no random idling on either side
    logic      hold_sink;  // long receiver hold-off
    int        hold_cycles;

    // ---------------------------------------------------------------- model
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint mag, input bit neg);
        longint v;
        v = neg ? -mag : mag;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint atan_step(input int idx);
        longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023,
            511, 255, 127};
        return tab[idx];
    endfunction

    // Angle of (x, y) by CORDIC vectoring; floor shifts, negative clamped
    function automatic longint vector_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z < 0 ? 0 : z;
    endfunction

    function automatic t_out_beat predict_error(input t_in_beat b);
        t_out_beat r;
        longint aw, ax, ay, az, nw, nx, ny, nz, q[4];
        logic [63:0] mag[3], v2, n2, nq, vm, u, th;
        logic [127:0] lhs, rhs, prod;
        bit neg[3], near;
        aw = b.want_w; ax = b.want_x; ay = b.want_y; az = b.want_z;
        nw = b.now_w;  nx = b.now_x;  ny = b.now_y;  nz = b.now_z;
        q[0] = (aw * nw + ax * nx + ay * ny + az * nz) >>> 2;
        q[1] = (-aw * nx + nw * ax - ay * nz + az * ny) >>> 2;
        q[2] = (-aw * ny + nw * ay - az * nx + ax * nz) >>> 2;
        q[3] = (-aw * nz + nw * az - ax * ny + ay * nx) >>> 2;
        r = '0;
        if (q[0] == 0 && q[1] == 0 && q[2] == 0 && q[3] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        if (q[0] < 0) for (int k = 0; k < 4; k++) q[k] = -q[k];
        v2 = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = q[k + 1] < 0;
            mag[k] = neg[k] ? -q[k + 1] : q[k + 1];
            v2 += mag[k] * mag[k];
        end
        n2 = v2 + q[0] * q[0];
        nq = root64(n2);
        vm = root64(v2);
        if (!log_kind) begin
            r.err_x = clamp16((2 * (mag[0] << 13) + nq) / (2 * nq), neg[0]);
            r.err_y = clamp16((2 * (mag[1] << 13) + nq) / (2 * nq), neg[1]);
            r.err_z = clamp16((2 * (mag[2] << 13) + nq) / (2 * nq), neg[2]);
            return r;
        end
        lhs  = 128'(v2) << 16;
        rhs  = 128'(n2) * near_limit;
        near = (vm == 0) || (lhs < rhs);
        if (near) begin
            r.used_small_angle = 1'b1;
            r.err_x = clamp16((2 * (mag[0] << 14) + nq) / (2 * nq), neg[0]);
            r.err_y = clamp16((2 * (mag[1] << 14) + nq) / (2 * nq), neg[1]);
            r.err_z = clamp16((2 * (mag[2] << 14) + nq) / (2 * nq), neg[2]);
            return r;
        end
        th = 2 * vector_angle(q[0], vm);
        for (int k = 0; k < 3; k++) begin
            u = (mag[k] << 30) / vm;
            prod = (128'(th) * u + (128'd1 << 46)) >> 47;
            if (k == 0) r.err_x = clamp16(prod[63:0], neg[k]);
            if (k == 1) r.err_y = clamp16(prod[63:0], neg[k]);
            if (k == 2) r.err_z = clamp16(prod[63:0], neg[k]);
        end
        return r;
    endfunction

    // -------------------------------------------------------------- driving
    // Offer one beat; hold it until the block takes it.
    task automatic send_pair(input t_in_beat b, input bit with_gaps);
        while (with_gaps && !calm && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        errors_due.push_back(predict_error(b));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (errors_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ERROR_KIND) log_kind = val[0];
        else near_limit = val;
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly unit quaternions pairs with small to large separation
    function automatic t_in_beat rand_pair();
        t_in_beat b;
        real a[4], n, s;
        if ($urandom_range(9) == 0) begin
            b = {rand_part(), rand_part(), rand_part(), rand_part(),
                 rand_part(), rand_part(), rand_part(), rand_part()};
            return b;
        end
        n = 0;
        for (int k = 0; k < 4; k++) begin
            a[k] = real'($signed(16'($urandom))) ;
            n += a[k] * a[k];
        end
        s = 32000.0 / $sqrt(n + 1.0);
        b.now_w = 16'($rtoi(a[0] * s)); b.now_x = 16'($rtoi(a[1] * s));
        b.now_y = 16'($rtoi(a[2] * s)); b.now_z = 16'($rtoi(a[3] * s));
        b.want_w = b.now_w; b.want_x = b.now_x;
        b.want_y = b.now_y; b.want_z = b.now_z;
        case ($urandom_range(3))
            0: ;
            1: begin
                b.want_x = b.want_x + 16'($signed($urandom_range(60)) - 30);
                b.want_w = b.want_w + 16'($signed($urandom_range(6)) - 3);
            end
            2: begin
                b.want_y = b.want_y + 16'($signed($urandom_range(4000)) - 2000);
                b.want_z = b.want_z + 16'($signed($urandom_range(4000)) - 2000);
            end
            default: b.want_w = 16'($urandom);
        endcase
        return b;
    endfunction

    // --------------------------------------------------------- directed rows
    typedef struct {
        t_in_beat  pair;
        bit        typed;  // expected value given in the row
        t_out_beat want;
    } t_row;

    localparam logic [15:0] ONE = 16'h7fff;
    localparam logic [15:0] MIN = 16'h8000;

    t_row rows[] = '{
        // identity against identity: zero vector, near-identity form
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0}, 1, '{0, 0, 0, 1'b1, 1'b0}},
        // zero difference: degenerate flag
        '{'{0, 0, 0, 0, ONE, 0, 0, 0}, 1, '{0, 0, 0, 1'b0, 1'b1}},
        '{'{ONE, ONE, ONE, ONE, 0, 0, 0, 0}, 1, '{0, 0, 0, 1'b0, 1'b1}},
        // negative scalar part folded, still identity
        '{'{MIN, 0, 0, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        // half turn about x: scalar part exactly zero
        '{'{0, ONE, 0, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        '{'{0, 0, MIN, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        '{'{0, 0, 0, ONE, 0, 0, 0, MIN}, 0, '{default: 0}},
        '{'{MIN, MIN, MIN, MIN, MIN, MIN, MIN, MIN}, 0, '{default: 0}},
        '{'{ONE, MIN, ONE, MIN, MIN, ONE, MIN, ONE}, 0, '{default: 0}},
        '{'{ONE, 16'd40, 0, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        '{'{ONE, 0, 16'd2000, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        '{'{16'd23170, 16'd23170, 0, 0, ONE, 0, 0, 0}, 0, '{default: 0}},
        '{'{16'd1, 0, 0, 0, 16'd1, 0, 0, 0}, 0, '{default: 0}},
        '{'{16'd1, 16'd1, 0, 0, 0, 0, 16'd1, 0}, 0, '{default: 0}},
        '{'{16'hffff, 16'd5, 16'hfffb, 16'd3, ONE, 0, 0, 0}, 0, '{default: 0}}
    };

    // ------------------------------------------------------ hold-off count
    // Count the cycles of the long receiver hold-off; restart while idle.
    always @(posedge i_clk) begin
        if (!hold_sink) begin
            hold_cycles <= 0;
        end else if (hold_cycles < 300) begin
            hold_cycles <= hold_cycles + 1;
        end
    end

    // ------------------------------------------------------------- receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (errors_due.size() == 0) begin
                    $error("result beat with no pair outstanding");
                    fail_count++;
                end else begin
                    t_out_beat e;
                    e = errors_due.pop_front();
                    if (out_ch.data.err_x !== e.err_x) begin
                        $error("err_x expected %0d got %0d", e.err_x, out_ch.data.err_x);
                        fail_count++;
                    end
                    if (out_ch.data.err_y !== e.err_y) begin
                        $error("err_y expected %0d got %0d", e.err_y, out_ch.data.err_y);
                        fail_count++;
                    end
                    if (out_ch.data.err_z !== e.err_z) begin
                        $error("err_z expected %0d got %0d", e.err_z, out_ch.data.err_z);
                        fail_count++;
                    end
                    if (out_ch.data.used_small_angle !== e.used_small_angle) begin
                        $error("used_small_angle expected %0b got %0b",
                               e.used_small_angle, out_ch.data.used_small_angle);
                        fail_count++;
                    end
                    if (out_ch.data.degenerate !== e.degenerate) begin
                        $error("degenerate expected %0b got %0b",
                               e.degenerate, out_ch.data.degenerate);
                        fail_count++;
                    end
                end
            end
            // stall at random, or hold off for a counted stretch
            if (hold_sink && hold_cycles < 300) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------- stimulus
    initial begin
        t_in_beat b;
        fail_count  = 0;
        calm        = 1'b0;
        hold_sink   = 1'b0;
        log_kind    = ERROR_KIND_RST;
        near_limit  = NEAR_LIMIT_RST;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_ERROR_KIND;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset setting; typed rows replace the model prediction
        foreach (rows[i]) begin
            send_pair(rows[i].pair, 1'b0);
            if (rows[i].typed) errors_due[$] = rows[i].want;
        end
        drain_results();

        // Walk settings: plain, log with limits 0, top, 2000, then reset-like
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_ERROR_KIND, 16'd0); write_reg(CFG_NEAR_LIMIT, 16'd66); end
                1: begin write_reg(CFG_ERROR_KIND, 16'd1); write_reg(CFG_NEAR_LIMIT, 16'd0); end
                2: write_reg(CFG_NEAR_LIMIT, 16'hffff);
                3: write_reg(CFG_NEAR_LIMIT, 16'd2000);
                default: write_reg(CFG_NEAR_LIMIT, 16'd66);
            endcase
            foreach (rows[i]) send_pair(rows[i].pair, 1'b0);
            for (int n = 0; n < 210; n++) begin
                calm = (phase == 1 && n >= 60 && n < 140);
                // long receiver hold-off while the sender keeps offering
                if (phase == 2 && n == 20) hold_sink = 1'b1;
                if (phase == 2 && n == 150) hold_sink = 1'b0;
                // sender pauses until all results are back
                if (phase == 3 && n == 100) begin
                    in_ch.valid <= 1'b0;
                    while (errors_due.size() != 0) @(posedge i_clk);
                end
                b = rand_pair();
                send_pair(b, 1'b1);
            end
            calm = 1'b0;
            drain_results();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> quaternion_orientation_error.f
rtl/core/qoe_pkg.sv
rtl/core/qoe_stream_if.sv
rtl/core/quaternion_orientation_error.sv
test/quaternion_orientation_error_test.sv
